[src/lprf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprf_pkg
// Shared types and constants for the longest prime run finder.
// ----------------------------------------------------------------------------
package lprf_pkg;

    localparam int VALUE_W   = 32;
    localparam int OUT_IDX_W = 16;
    localparam int M_DATA_W  = 40;
    localparam int DIV_W     = 17;
    localparam int SQ_W      = 34;
    localparam int CNT_W     = 5;

    // Verdict from the front: settled at once or left for trial division
    typedef enum logic [1:0]
    {
        KIND_NOT_PRIME,
        KIND_PRIME,
        KIND_ODD_TEST
    } item_kind_t;

    typedef struct packed
    {
        logic [VALUE_W-1:0] value;
        logic               last;
        item_kind_t         kind;
    } item_t;

    typedef struct packed
    {
        logic done;
        logic prime;
    } test_res_t;

    typedef enum logic [1:0]
    {
        T_IDLE,
        T_CHECK,
        T_DIV
    } test_state_t;

    typedef enum logic [1:0]
    {
        BK_IDLE,
        BK_TEST,
        BK_APPLY
    } back_state_t;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

endpackage

[src/longest_prime_run_finder_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_prime_run_finder_top
// Finds the longest run of consecutive primes in a stream of signed words.
//
// Channel  Dir  Payload
// s_*      in   tdata[31:0] value, tlast marks the final word of a sequence
// m_*      out  tdata[15:0] best_start, [31:16] best_end, [32] found
//
// Values below two, two itself and even values settle without division.
// An odd value n takes one remainder per odd divisor tried, up to
// sqrt(n)/2 divisors; the single restoring remainder unit works one bit
// per cycle.
// A two-word queue lets input be taken while the back end divides, and the
// back end stalls only on a final word while the previous result waits.
// Reset is asynchronous and active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
module longest_prime_run_finder_top
    import lprf_pkg::*;
#(
    parameter int INDEX_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [VALUE_W-1:0]  s_tdata,   // [31:0] value
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // [15:0] best_start, [31:16] best_end,
                                           // [32] found, [39:33] zero
);

    logic      push;
    item_t     push_item;
    logic      queue_ready;
    logic      pop;
    logic      head_valid;
    item_t     head_item;
    logic      test_start;
    test_res_t test_res;

    lprf_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .push        (push),
        .push_item   (push_item),
        .queue_ready (queue_ready)
    );

    lprf_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .ready      (queue_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    lprf_prime_test u_test
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (test_start),
        .operand (head_item.value),
        .res     (test_res)
    );

    lprf_run_track #(
        .INDEX_BITS (INDEX_BITS)
    ) u_track
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .test_start (test_start),
        .test_res   (test_res),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

[src/lprf_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprf_front
// Input stage: takes words, sorts out the values with an obvious verdict
// and registers them for the queue.
// ----------------------------------------------------------------------------
module lprf_front
    import lprf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [VALUE_W-1:0] s_tdata,   // [31:0] value
    input  logic               s_tlast,
    output logic               push,
    output item_t              push_item,
    input  logic               queue_ready
);

    logic       stage_valid_reg;
    logic       stage_valid_next;
    item_t      stage_item_reg;
    item_kind_t kind;
    logic       take;

    always_comb
    begin
        // negatives and values below two are never prime
        if (s_tdata[VALUE_W-1] || (s_tdata < VALUE_W'(2)))
            kind = KIND_NOT_PRIME;
        else if (s_tdata == VALUE_W'(2))
            kind = KIND_PRIME;
        else if (!s_tdata[0])
            kind = KIND_NOT_PRIME;
        else
            kind = KIND_ODD_TEST;
    end

    assign push      = stage_valid_reg && queue_ready;
    assign push_item = stage_item_reg;
    assign s_tready  = !stage_valid_reg || queue_ready;
    assign take      = s_tvalid && s_tready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (take)
            stage_valid_next = 1'b1;
        else if (push)
            stage_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_item_reg.value <= s_tdata;
            stage_item_reg.last  <= s_tlast;
            stage_item_reg.kind  <= kind;
        end
    end

endmodule

[src/lprf_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprf_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module lprf_queue
    import lprf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  ready,
    input  logic  pop,
    output logic  head_valid,
    output item_t head_item
);

    item_t             mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign ready      = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

endmodule

[src/lprf_prime_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprf_prime_test
// Trial division of an odd value by 3, 5, 7, ... while d*d <= value.
// One remainder takes one restoring step per bit of the value.
// ----------------------------------------------------------------------------
module lprf_prime_test
    import lprf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [VALUE_W-1:0] operand,
    output test_res_t          res
);

    test_state_t        state_reg;
    test_state_t        state_next;
    logic [VALUE_W-1:0] n_reg;
    logic [VALUE_W-1:0] shift_reg;
    logic [DIV_W-1:0]   d_reg;
    logic [SQ_W-1:0]    sq_reg;
    logic [DIV_W-2:0]   rem_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [DIV_W-1:0]   trial;
    logic [DIV_W-1:0]   trial_sub;
    logic [DIV_W-2:0]   rem_step;

    assign trial     = {rem_reg, shift_reg[VALUE_W-1]};
    assign trial_sub = trial - d_reg;
    assign rem_step  = (trial >= d_reg) ? trial_sub[DIV_W-2:0] : trial[DIV_W-2:0];

    always_comb
    begin
        state_next = state_reg;
        res.done   = 1'b0;
        res.prime  = 1'b0;
        case (state_reg)
            T_IDLE:
            begin
                if (start)
                    state_next = T_CHECK;
            end
            T_CHECK:
            begin
                if (sq_reg > SQ_W'(n_reg))
                begin
                    res.done   = 1'b1;
                    res.prime  = 1'b1;
                    state_next = T_IDLE;
                end
                else
                    state_next = T_DIV;
            end
            T_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    if (rem_step == '0)
                    begin
                        res.done   = 1'b1;
                        state_next = T_IDLE;
                    end
                    else
                        state_next = T_CHECK;
                end
            end
            default:
                state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= T_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            T_IDLE:
            begin
                n_reg  <= operand;
                d_reg  <= DIV_W'(3);
                sq_reg <= SQ_W'(9);
            end
            T_CHECK:
            begin
                shift_reg <= n_reg;
                rem_reg   <= '0;
                cnt_reg   <= CNT_W'(VALUE_W - 1);
            end
            T_DIV:
            begin
                shift_reg <= {shift_reg[VALUE_W-2:0], 1'b0};
                rem_reg   <= rem_step;
                cnt_reg   <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    // advance to the next odd divisor: (d+2)^2 = d^2 + 4d + 4
                    d_reg  <= d_reg + DIV_W'(2);
                    sq_reg <= sq_reg + {d_reg, 2'b00} + SQ_W'(4);
                end
            end
            default:
            begin
                n_reg <= n_reg;
            end
        endcase
    end

endmodule

[src/lprf_run_track.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprf_run_track
// Back end: takes verdicts in order, tracks the current and best prime
// runs and presents the result word at the end of each sequence.
// ----------------------------------------------------------------------------
module lprf_run_track
    import lprf_pkg::*;
#(
    parameter int INDEX_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  item_t               head_item,
    output logic                pop,
    output logic                test_start,
    input  test_res_t           test_res,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata   // [15:0] best_start, [31:16] best_end,
                                          // [32] found, [39:33] zero
);

    localparam int IW = INDEX_BITS;

    back_state_t     state_reg;
    back_state_t     state_next;
    logic            verdict_reg;
    logic            verdict_next;
    logic [IW-1:0]   pos_reg;
    logic [IW-1:0]   run_start_reg;
    logic [IW-1:0]   run_end_reg;
    logic [IW-1:0]   best_first_reg;
    logic [IW-1:0]   best_last_reg;
    logic            prev_prime_reg;
    logic            out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;

    logic            apply;
    logic [IW-1:0]   pos_inc;
    logic [IW-1:0]   rs_upd;
    logic [IW-1:0]   re_upd;
    logic [IW-1:0]   bf_step;
    logic [IW-1:0]   bl_step;
    logic [IW-1:0]   bf_fin;
    logic [IW-1:0]   bl_fin;
    logic [IW+OUT_IDX_W-1:0] bf_wide;
    logic [IW+OUT_IDX_W-1:0] bl_wide;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        state_next   = state_reg;
        verdict_next = verdict_reg;
        test_start   = 1'b0;
        apply        = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (head_valid)
                begin
                    if (head_item.kind == KIND_ODD_TEST)
                    begin
                        test_start = 1'b1;
                        state_next = BK_TEST;
                    end
                    else
                    begin
                        verdict_next = (head_item.kind == KIND_PRIME);
                        state_next   = BK_APPLY;
                    end
                end
            end
            BK_TEST:
            begin
                if (test_res.done)
                begin
                    verdict_next = test_res.prime;
                    state_next   = BK_APPLY;
                end
            end
            BK_APPLY:
            begin
                // hold a closing word while the previous result is untaken
                if (!(head_item.last && out_valid_reg && !m_tready))
                begin
                    apply      = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
                state_next = BK_IDLE;
        endcase
    end

    assign pop = apply;

    always_comb
    begin
        pos_inc = (pos_reg != {IW{1'b1}}) ? pos_reg + 1'b1 : pos_reg;
        rs_upd  = run_start_reg;
        re_upd  = run_end_reg;
        bf_step = best_first_reg;
        bl_step = best_last_reg;
        if (verdict_reg)
        begin
            if (!prev_prime_reg)
                rs_upd = pos_inc;
            re_upd = pos_inc;
        end
        else if ((best_last_reg - best_first_reg) < (run_end_reg - run_start_reg))
        begin
            bf_step = run_start_reg;
            bl_step = run_end_reg;
        end
        bf_fin = bf_step;
        bl_fin = bl_step;
        if ((bl_step - bf_step) < (re_upd - rs_upd))
        begin
            bf_fin = rs_upd;
            bl_fin = re_upd;
        end
        bf_wide = {{OUT_IDX_W{1'b0}}, bf_fin};
        bl_wide = {{OUT_IDX_W{1'b0}}, bl_fin};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            verdict_reg    <= 1'b0;
            pos_reg        <= '0;
            run_start_reg  <= '0;
            run_end_reg    <= '0;
            best_first_reg <= '0;
            best_last_reg  <= '0;
            prev_prime_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            verdict_reg <= verdict_next;
            if (apply && head_item.last)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            if (apply)
            begin
                if (head_item.last)
                begin
                    // close the sequence and start afresh
                    pos_reg        <= '0;
                    run_start_reg  <= '0;
                    run_end_reg    <= '0;
                    best_first_reg <= '0;
                    best_last_reg  <= '0;
                    prev_prime_reg <= 1'b0;
                end
                else
                begin
                    pos_reg        <= pos_inc;
                    run_start_reg  <= rs_upd;
                    run_end_reg    <= re_upd;
                    best_first_reg <= bf_step;
                    best_last_reg  <= bl_step;
                    prev_prime_reg <= verdict_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (apply && head_item.last)
            out_data_reg <= {7'b0, (bl_fin != '0), bl_wide[OUT_IDX_W-1:0],
                             bf_wide[OUT_IDX_W-1:0]};
    end

endmodule

[tb/sv/tb_longest_prime_run_finder_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_longest_prime_run_finder_top
// Streams sequences of signed words into the prime run finder and checks
// every reported run against a behavioural predictor of its own.
//
// A directed part covers the value extremes, squares of primes, ties, a
// lone prime and sequences with no run. Random sequences follow, mostly
// cheap to test, with large values built from small factors. Both sides
// idle at random. The receiver holds off once for a long stretch, and the
// sender once waits until every report has come back.
// ----------------------------------------------------------------------------
module tb_longest_prime_run_finder_top;
    import lprf_pkg::*;

    localparam int  IDX_W          = 16;
    localparam int  RANDOM_WORDS   = 72;
    localparam int  HOLD_CYCLES    = 3000;
    localparam int  TAIL_CYCLES    = 2000;
    localparam int  CYCLE_LIMIT    = 8_000_000;
    localparam logic [IDX_W-1:0] IDX_MAX = '1;

    typedef enum logic
    {
        OP_WORD,
        OP_DRAIN
    } stim_op_t;

    typedef struct
    {
        stim_op_t           op;
        logic [VALUE_W-1:0] value;
        logic               last;
    } pending_word_t;

    typedef struct
    {
        logic [OUT_IDX_W-1:0] start_idx;
        logic [OUT_IDX_W-1:0] end_idx;
        logic                 found;
    } run_report_t;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [VALUE_W-1:0]  s_tdata  = '0;
    logic                s_tlast  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    pending_word_t stimulus[$];
    run_report_t   expected_reports[$];
    pending_word_t next_word;
    run_report_t   want;

    // Predictor state
    logic [IDX_W-1:0] seq_pos    = '0;
    logic             prev_prime = 1'b0;
    logic [IDX_W-1:0] run_first  = '0;
    logic [IDX_W-1:0] run_last   = '0;
    logic [IDX_W-1:0] best_first = '0;
    logic [IDX_W-1:0] best_last  = '0;

    logic word_taken   = 1'b0;
    int   in_count     = 0;
    int   words_queued = 0;
    int   hold_at      = 32'h7FFF_FFFF;
    int   calm_at      = 32'h7FFF_FFFF;
    int   send_gap     = 0;
    int   recv_gap     = 0;
    int   hold_left    = 0;
    logic hold_started = 1'b0;
    int   mismatches   = 0;
    int   cycle_count  = 0;
    wire  calm         = (in_count >= calm_at);

    longest_prime_run_finder_top #(
        .INDEX_BITS (IDX_W)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 clk = ~clk;

    function automatic bit value_is_prime(input logic signed [VALUE_W-1:0] v);
        longint unsigned n;
        longint unsigned d;
        if (v < 2)
            return 1'b0;
        n = longint'(v);
        if (n == 2)
            return 1'b1;
        if (n[0] == 1'b0)
            return 1'b0;
        for (d = 3; d * d <= n; d += 2)
        begin
            if (n % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Keep the earlier run on a tie
    task automatic close_open_run();
        if ((best_last - best_first) < (run_last - run_first))
        begin
            best_first = run_first;
            best_last  = run_last;
        end
    endtask

    task automatic absorb_word(input logic [VALUE_W-1:0] word, input logic is_last);
        bit          p;
        run_report_t rep;
        if (seq_pos != IDX_MAX)
            seq_pos = seq_pos + 1'b1;
        p = value_is_prime($signed(word));
        if (p)
        begin
            if (!prev_prime)
                run_first = seq_pos;
            run_last = seq_pos;
        end
        else
            close_open_run();
        prev_prime = p;
        if (is_last)
        begin
            close_open_run();
            rep.start_idx = best_first[OUT_IDX_W-1:0];
            rep.end_idx   = best_last[OUT_IDX_W-1:0];
            rep.found     = (best_last != 0);
            expected_reports.push_back(rep);
            seq_pos    = '0;
            prev_prime = 1'b0;
            run_first  = '0;
            run_last   = '0;
            best_first = '0;
            best_last  = '0;
        end
    endtask

    task automatic check_field(input string name, input logic [M_DATA_W-1:0] exp_v,
                               input logic [M_DATA_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    task automatic queue_word(input logic [VALUE_W-1:0] value, input logic last);
        pending_word_t w;
        w.op    = OP_WORD;
        w.value = value;
        w.last  = last;
        stimulus.push_back(w);
        words_queued++;
    endtask

    task automatic queue_drain();
        pending_word_t w;
        w.op    = OP_DRAIN;
        w.value = '0;
        w.last  = 1'b0;
        stimulus.push_back(w);
    endtask

    // Sample both handshakes; check the result before predicting from the
    // word taken at the same edge
    always @(posedge clk)
    begin
        word_taken <= s_tvalid && s_tready;
        if (m_tvalid && m_tready)
        begin
            if (expected_reports.size() == 0)
            begin
                $error("result word with no report expected: %h", m_tdata);
                mismatches++;
            end
            else
            begin
                want = expected_reports.pop_front();
                check_field("best_start", M_DATA_W'(want.start_idx),
                            M_DATA_W'(m_tdata[15:0]));
                check_field("best_end", M_DATA_W'(want.end_idx),
                            M_DATA_W'(m_tdata[31:16]));
                check_field("found", M_DATA_W'(want.found), M_DATA_W'(m_tdata[32]));
                check_field("padding", '0, M_DATA_W'(m_tdata[M_DATA_W-1:33]));
            end
        end
        if (s_tvalid && s_tready)
        begin
            in_count <= in_count + 1;
            absorb_word(s_tdata, s_tlast);
        end
    end

    // Sender
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || word_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                send_gap <= $urandom_range(0, 14);
                s_tvalid <= 1'b0;
            end
            else if (stimulus.size() != 0 && stimulus[0].op == OP_DRAIN)
            begin
                // hold until every report is back
                s_tvalid <= 1'b0;
                if (expected_reports.size() == 0)
                    next_word = stimulus.pop_front();
            end
            else if (stimulus.size() != 0)
            begin
                next_word = stimulus.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= next_word.value;
                s_tlast  <= next_word.last;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_started && in_count >= hold_at)
            begin
                hold_started <= 1'b1;
                hold_left    <= HOLD_CYCLES;
                m_tready     <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                recv_gap <= $urandom_range(0, 14);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_longest_prime_run_finder_top NOT OK");
            $finish;
        end
    end

    initial
    begin
        logic [VALUE_W-1:0] v;
        int                 len;
        int                 f;
        int                 n;

        // Extremes, small values, run closed by a later composite
        queue_word(32'h8000_0000, 1'b0);
        queue_word(0, 1'b0);
        queue_word(1, 1'b0);
        queue_word(2, 1'b0);
        queue_word(3, 1'b0);
        queue_word(4, 1'b0);
        queue_word(5, 1'b0);
        queue_word(7, 1'b0);
        queue_word(11, 1'b0);
        queue_word(9, 1'b1);
        // A lone prime is never reported
        queue_word(7, 1'b1);
        // Tie keeps the earlier run
        queue_word(2, 1'b0);
        queue_word(3, 1'b0);
        queue_word(4, 1'b0);
        queue_word(5, 1'b0);
        queue_word(7, 1'b1);
        // Squares of primes only: no run
        queue_word(4, 1'b0);
        queue_word(25, 1'b0);
        queue_word(49, 1'b0);
        queue_word(63001, 1'b1);
        // Largest positive value is prime
        queue_word(32'h7FFF_FFFF, 1'b0);
        queue_word(65521, 1'b0);
        queue_word(32'h7FFF_FFFE, 1'b0);
        queue_word(32'h5555_5555, 1'b1);
        // Run still open on the final word
        queue_word(4, 1'b0);
        queue_word(3, 1'b0);
        queue_word(5, 1'b1);
        queue_drain();

        hold_at = words_queued + 5;
        n = 0;
        while (n < RANDOM_WORDS)
        begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2:
                    begin
                        v = 4;
                        while (!value_is_prime(v))
                            v = $urandom_range(2, 255);
                    end
                    3, 4:    v = $urandom_range(0, 255);
                    5:       v = $urandom_range(256, 4095);
                    6:       v = $urandom | 32'h8000_0000;
                    7:       v = $urandom & 32'hFFFF_FFFE;
                    default:
                    begin
                        // large odd value with a small factor
                        f = 3 + 2 * $urandom_range(0, 5);
                        v = f * ($urandom_range(1, 32'h7FFF_FFFF / f) | 1);
                    end
                endcase
                queue_word(v, i == len - 1);
            end
            n += len;
        end
        calm_at = words_queued - 20;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (stimulus.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb_longest_prime_run_finder_top OK");
        else
            $display("tb_longest_prime_run_finder_top NOT OK");
        $finish;
    end

endmodule
